[sv/eprm_pkg.sv]
`timescale 1ns / 1ps
package eprm_pkg;

   // defaults for the top-level parameters
   localparam int COUNT_WIDTH_DEF      = 32;
   localparam int TICKS_PER_SECOND_DEF = 1000000;
   localparam int HZ_TO_RPM_DEF        = 60;

   // fixed field widths
   localparam int RPM_W        = 26;
   localparam int PERIOD_OUT_W = 32;
   localparam int MAXP_W       = 32;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 32;

   localparam logic [MAXP_W-1:0] MAX_PERIOD_RST = MAXP_W'(1000000);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_MODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PERIOD = 2'd2;

   // edge modes
   localparam logic [1:0] MODE_LOW    = 2'd0;
   localparam logic [1:0] MODE_CHANGE = 2'd1;
   localparam logic [1:0] MODE_RISE   = 2'd2;
   localparam logic [1:0] MODE_FALL   = 2'd3;

   // commands from front to back
   localparam logic [1:0] OP_KEEP    = 2'd0;
   localparam logic [1:0] OP_DROP    = 2'd1;
   localparam logic [1:0] OP_MEASURE = 2'd2;

   localparam int FIFO_DEPTH = 2;

   typedef struct packed {
      logic [1:0] op;
      logic       time_ok;
   } cmd_ctl_type;

   localparam int CTL_W = $bits(cmd_ctl_type);

endpackage

[sv/eprm_fifo.sv]
`timescale 1ns / 1ps
module eprm_fifo
   import eprm_pkg::*;
#(
   parameter int WIDTH = 35
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [WIDTH-1:0] mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/eprm_front.sv]
`timescale 1ns / 1ps
module eprm_front
   import eprm_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_pin_level,
   input  logic                   req_restart,
   input  logic                   cmd_full,
   output logic                   cmd_push,
   output cmd_ctl_type            cmd_ctl,
   output logic [COUNT_WIDTH-1:0] cmd_period
);

   localparam int CMP_W = (COUNT_WIDTH > MAXP_W) ? COUNT_WIDTH : MAXP_W;

   logic                   enabled_ff, enabled_in;
   logic [1:0]             edge_mode_ff, edge_mode_in;
   logic [MAXP_W-1:0]      max_period_ff, max_period_in;
   logic                   last_pin_ff;
   logic                   have_ref_ff, have_ref_in;
   logic [COUNT_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_WIDTH-1:0] elapsed_inc;
   logic                   edge_hit;

   assign req_ready = !cmd_full;
   assign cmd_push  = req_valid && req_ready;

   // config writes
   always_comb begin
      enabled_in    = enabled_ff;
      edge_mode_in  = edge_mode_ff;
      max_period_in = max_period_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLED:    enabled_in = csr_wdata[0];
            CSR_EDGE_MODE:  if (!enabled_ff) edge_mode_in = csr_wdata[1:0];
            CSR_MAX_PERIOD: max_period_in = csr_wdata[MAXP_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (edge_mode_ff)
         MODE_LOW:    edge_hit = !req_pin_level;
         MODE_CHANGE: edge_hit = req_pin_level != last_pin_ff;
         MODE_RISE:   edge_hit = req_pin_level && !last_pin_ff;
         MODE_FALL:   edge_hit = !req_pin_level && last_pin_ff;
         default:     edge_hit = 1'b0;
      endcase
   end

   // saturating tick counter
   assign elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + 1'b1;

   always_comb begin
      elapsed_in  = elapsed_inc;
      have_ref_in = have_ref_ff;
      cmd_ctl.op  = OP_KEEP;
      if (req_restart) begin
         elapsed_in  = '0;
         have_ref_in = 1'b1;
         cmd_ctl.op  = OP_DROP;
      end else if (enabled_ff && edge_hit) begin
         elapsed_in  = '0;
         have_ref_in = 1'b1;
         cmd_ctl.op  = (have_ref_ff && !(&elapsed_inc)) ? OP_MEASURE : OP_DROP;
      end
      cmd_ctl.time_ok = CMP_W'(elapsed_in) < CMP_W'(max_period_ff);
   end

   assign cmd_period = elapsed_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= 1'b0;
         edge_mode_ff  <= MODE_RISE;
         max_period_ff <= MAX_PERIOD_RST;
         last_pin_ff   <= 1'b0;
         have_ref_ff   <= 1'b0;
         elapsed_ff    <= '0;
      end else begin
         enabled_ff    <= enabled_in;
         edge_mode_ff  <= edge_mode_in;
         max_period_ff <= max_period_in;
         if (cmd_push) begin
            last_pin_ff <= req_pin_level;
            have_ref_ff <= have_ref_in;
            elapsed_ff  <= elapsed_in;
         end
      end
   end

endmodule

[sv/eprm_back.sv]
`timescale 1ns / 1ps
module eprm_back
   import eprm_pkg::*;
#(
   parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF,
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
   parameter int HZ_TO_RPM        = HZ_TO_RPM_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  cmd_ctl_type             cmd_ctl,
   input  logic [COUNT_WIDTH-1:0]  cmd_period,
   output logic                    cmd_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [RPM_W-1:0]        rsp_rpm,
   output logic                    rsp_rpm_valid,
   output logic [PERIOD_OUT_W-1:0] rsp_period_ticks
);

   localparam int QUOT_W = $clog2(TICKS_PER_SECOND + 1);
   localparam int REM_W  = ((COUNT_WIDTH > QUOT_W) ? COUNT_WIDTH : QUOT_W) + 1;
   localparam int DCNT_W = $clog2(QUOT_W + 1);
   localparam int PROD_W = QUOT_W + $clog2(HZ_TO_RPM + 1);
   localparam int SAT_W  = (PROD_W > RPM_W) ? PROD_W : RPM_W;
   localparam logic [QUOT_W-1:0] DIVIDEND = QUOT_W'(TICKS_PER_SECOND);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_SAT  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic                    time_ok_ff, time_ok_in;
   logic [COUNT_WIDTH-1:0]  period_ff, period_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [QUOT_W-1:0]       quot_ff, quot_in;
   logic [DCNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [COUNT_WIDTH-1:0]  meas_period_ff, meas_period_in;
   logic                    period_known_ff, period_known_in;
   logic [RPM_W-1:0]        rpm_value_ff, rpm_value_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RPM_W-1:0]        rsp_rpm_ff, rsp_rpm_in;
   logic                    rsp_rpm_valid_ff, rsp_rpm_valid_in;
   logic [PERIOD_OUT_W-1:0] rsp_period_ff, rsp_period_in;
   logic [REM_W-1:0]        rem_shift;
   logic                    quot_bit;
   logic [SAT_W-1:0]        prod_ext;
   logic                    out_free;
   logic                    rd_valid;

   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rem_shift = {rem_ff[REM_W-2:0], quot_ff[QUOT_W-1]};
   assign quot_bit  = rem_shift >= REM_W'(period_ff);
   assign prod_ext  = SAT_W'(prod_ff);
   assign rd_valid  = period_known_ff && time_ok_ff;

   always_comb begin
      state_in         = state_ff;
      time_ok_in       = time_ok_ff;
      period_in        = period_ff;
      rem_in           = rem_ff;
      quot_in          = quot_ff;
      div_cnt_in       = div_cnt_ff;
      prod_in          = prod_ff;
      meas_period_in   = meas_period_ff;
      period_known_in  = period_known_ff;
      rpm_value_in     = rpm_value_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_rpm_in       = rsp_rpm_ff;
      rsp_rpm_valid_in = rsp_rpm_valid_ff;
      rsp_period_in    = rsp_period_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               time_ok_in = cmd_ctl.time_ok;
               state_in   = S_OUT;
               unique case (cmd_ctl.op)
                  OP_MEASURE: begin
                     period_in  = cmd_period;
                     rem_in     = '0;
                     quot_in    = DIVIDEND;
                     div_cnt_in = DCNT_W'(QUOT_W);
                     state_in   = S_DIV;
                  end
                  OP_DROP: begin
                     meas_period_in  = '0;
                     period_known_in = 1'b0;
                     rpm_value_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         // restoring division, one quotient bit per cycle
         S_DIV: begin
            rem_in     = quot_bit ? rem_shift - REM_W'(period_ff) : rem_shift;
            quot_in    = {quot_ff[QUOT_W-2:0], quot_bit};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == DCNT_W'(1)) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(quot_ff) * PROD_W'(HZ_TO_RPM);
            state_in = S_SAT;
         end
         S_SAT: begin
            rpm_value_in    = (prod_ext > SAT_W'({RPM_W{1'b1}})) ? {RPM_W{1'b1}}
                                                                  : prod_ext[RPM_W-1:0];
            meas_period_in  = period_ff;
            period_known_in = 1'b1;
            state_in        = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_rpm_valid_in = rd_valid;
               rsp_rpm_in       = rd_valid ? rpm_value_ff : '0;
               rsp_period_in    = PERIOD_OUT_W'(meas_period_ff);
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         meas_period_ff  <= '0;
         period_known_ff <= 1'b0;
         rpm_value_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         meas_period_ff  <= meas_period_in;
         period_known_ff <= period_known_in;
         rpm_value_ff    <= rpm_value_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ok_ff       <= time_ok_in;
      period_ff        <= period_in;
      rem_ff           <= rem_in;
      quot_ff          <= quot_in;
      div_cnt_ff       <= div_cnt_in;
      prod_ff          <= prod_in;
      rsp_rpm_ff       <= rsp_rpm_in;
      rsp_rpm_valid_ff <= rsp_rpm_valid_in;
      rsp_period_ff    <= rsp_period_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rpm          = rsp_rpm_ff;
   assign rsp_rpm_valid    = rsp_rpm_valid_ff;
   assign rsp_period_ticks = rsp_period_ff;

   // a known period is never zero, an unknown one leaves everything cleared
   a_known_nonzero: assert property (@(posedge clock) disable iff (reset)
      period_known_ff |-> meas_period_ff != '0)
      else $error("known period is zero");

   a_unknown_clear: assert property (@(posedge clock) disable iff (reset)
      !period_known_ff |-> (meas_period_ff == '0 && rpm_value_ff == '0))
      else $error("dropped period left residue");

   a_rpm_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_rpm_valid_ff |-> rsp_rpm_ff == '0)
      else $error("rpm shown while reading stale");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> (div_cnt_ff != '0 && div_cnt_ff <= DCNT_W'(QUOT_W)))
      else $error("divider step count out of range");

endmodule

[sv/edge_period_rpm_meter_top.sv]
`timescale 1ns / 1ps
// Edge-period tachometer. Each req word is one tick of the sensor sample clock:
// req_pin_level is the sampled pin, req_restart restarts timing and drops the
// period. Every accepted req word yields exactly one rsp word, in order:
// rsp_period_ticks (last measured period, 0 if unknown), rsp_rpm =
// (TICKS_PER_SECOND / period) * HZ_TO_RPM saturated to 26 bits, and
// rsp_rpm_valid, low with no period or once the ticks since the last edge
// reach max_period (rsp_rpm is then 0).
// The front end tracks the pin and tick counter and accepts a word per cycle
// while its two-entry command queue has room. The back end answers ticks that
// measure nothing straight from idle via the output state; a measuring edge
// first runs a restoring divider, one quotient bit per cycle, then a multiply
// step and a saturate step. It takes the next queued word only once back in
// idle. An edge_mode write is ignored while the meter is enabled.
// A stalled rsp side holds the rsp register; the queue fills and req_ready
// drops until the rsp word is taken. csr writes take effect the next cycle.
// Synchronous reset clears the counter, reference and period, sets enabled=0,
// edge_mode=rising, max_period=1000000, and empties queue and output.
module edge_period_rpm_meter_top
   import eprm_pkg::*;
#(
   parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF,
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
   parameter int HZ_TO_RPM        = HZ_TO_RPM_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_pin_level,
   input  logic                    req_restart,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [RPM_W-1:0]        rsp_rpm,
   output logic                    rsp_rpm_valid,
   output logic [PERIOD_OUT_W-1:0] rsp_period_ticks
);

   localparam int Q_W = CTL_W + COUNT_WIDTH;

   logic                   push, full, pop, not_empty;
   cmd_ctl_type            push_ctl, pop_ctl;
   logic [COUNT_WIDTH-1:0] push_period, pop_period;
   logic [Q_W-1:0]         pop_data;

   eprm_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pin_level (req_pin_level),
      .req_restart   (req_restart),
      .cmd_full      (full),
      .cmd_push      (push),
      .cmd_ctl       (push_ctl),
      .cmd_period    (push_period)
   );

   eprm_fifo #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctl, push_period}),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   assign pop_ctl    = pop_data[Q_W-1:COUNT_WIDTH];
   assign pop_period = pop_data[COUNT_WIDTH-1:0];

   eprm_back #(
      .COUNT_WIDTH      (COUNT_WIDTH),
      .TICKS_PER_SECOND (TICKS_PER_SECOND),
      .HZ_TO_RPM        (HZ_TO_RPM)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (not_empty),
      .cmd_ctl          (pop_ctl),
      .cmd_period       (pop_period),
      .cmd_pop          (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rpm          (rsp_rpm),
      .rsp_rpm_valid    (rsp_rpm_valid),
      .rsp_period_ticks (rsp_period_ticks)
   );

endmodule

[bench/tach_checker.sv]
`timescale 1ns / 1ps
module tach_checker
   import eprm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    req_pin_level,
   input  logic                    req_restart,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [RPM_W-1:0]        rsp_rpm,
   input  logic                    rsp_rpm_valid,
   input  logic [PERIOD_OUT_W-1:0] rsp_period_ticks,
   output int                      mismatches,
   output int                      readings_pending
);

   localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_SAT = '1;
   localparam longint unsigned RPM_SAT = (64'd1 << RPM_W) - 1;
   localparam longint unsigned TICKS   = TICKS_PER_SECOND_DEF;
   localparam longint unsigned HZ_RPM  = HZ_TO_RPM_DEF;

   typedef struct packed {
      logic [RPM_W-1:0]        rpm;
      logic                    rpm_valid;
      logic [PERIOD_OUT_W-1:0] period;
   } reading_type;

   // register copies
   logic                       meas_en;
   logic [1:0]                 mode;
   logic [MAXP_W-1:0]          stale_after;

   // meter state
   logic                       prev_pin;
   logic                       have_ref;
   logic                       period_known;
   logic [COUNT_WIDTH_DEF-1:0] elapsed;
   logic [COUNT_WIDTH_DEF-1:0] period;
   logic [RPM_W-1:0]           rpm_hold;

   reading_type readings_due[$];

   initial begin
      mismatches       = 0;
      readings_pending = 0;
   end

   function automatic void clear_period();
      period       = '0;
      period_known = 1'b0;
      rpm_hold     = '0;
   endfunction

   // one tick of the meter; returns the reading it produces
   function automatic reading_type advance_tick(input logic pin, input logic rst);
      reading_type     r;
      logic            hit;
      longint unsigned quot;
      if (rst) begin
         elapsed  = '0;
         have_ref = 1'b1;
         clear_period();
      end else begin
         if (elapsed != COUNT_SAT)
            elapsed = elapsed + 1'b1;
         case (mode)
            MODE_LOW:    hit = !pin;
            MODE_CHANGE: hit = (pin != prev_pin);
            MODE_RISE:   hit = pin && !prev_pin;
            default:     hit = !pin && prev_pin;
         endcase
         if (meas_en && hit) begin
            if (have_ref && elapsed != COUNT_SAT) begin
               quot         = (TICKS / elapsed) * HZ_RPM;
               period       = elapsed;
               period_known = 1'b1;
               rpm_hold     = (quot > RPM_SAT) ? '1 : RPM_W'(quot);
            end else begin
               clear_period();
            end
            elapsed  = '0;
            have_ref = 1'b1;
         end
      end
      prev_pin    = pin;
      r.rpm_valid = period_known && (elapsed < stale_after);
      r.rpm       = r.rpm_valid ? rpm_hold : '0;
      r.period    = PERIOD_OUT_W'(period);
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         meas_en     = 1'b0;
         mode        = MODE_RISE;
         stale_after = MAX_PERIOD_RST;
         prev_pin    = 1'b0;
         have_ref    = 1'b0;
         elapsed     = '0;
         clear_period();
         readings_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ENABLED:    meas_en = csr_wdata[0];
               // mode is locked while measuring
               CSR_EDGE_MODE:  if (!meas_en) mode = csr_wdata[1:0];
               CSR_MAX_PERIOD: stale_after = csr_wdata[MAXP_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               $error("rsp word with no reading due: rpm %0d, rpm_valid %0b, period_ticks %0d",
                      rsp_rpm, rsp_rpm_valid, rsp_period_ticks);
               mismatches++;
            end else begin
               want = readings_due.pop_front();
               if (rsp_rpm !== want.rpm) begin
                  $error("rpm: expected %0d, actual %0d", want.rpm, rsp_rpm);
                  mismatches++;
               end
               if (rsp_rpm_valid !== want.rpm_valid) begin
                  $error("rpm_valid: expected %0b, actual %0b", want.rpm_valid, rsp_rpm_valid);
                  mismatches++;
               end
               if (rsp_period_ticks !== want.period) begin
                  $error("period_ticks: expected %0d, actual %0d",
                         want.period, rsp_period_ticks);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            readings_due.push_back(advance_tick(req_pin_level, req_restart));
      end
      readings_pending = readings_due.size();
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
   import eprm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 4000;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index      = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata      = '0;
   logic                    req_valid      = 1'b0;
   logic                    req_ready;
   logic                    req_pin_level  = 1'b0;
   logic                    req_restart    = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready      = 1'b0;
   logic [RPM_W-1:0]        rsp_rpm;
   logic                    rsp_rpm_valid;
   logic [PERIOD_OUT_W-1:0] rsp_period_ticks;

   int mismatches;
   int readings_pending;
   int quiet_cycles = 0;
   bit steady       = 1'b0;

   edge_period_rpm_meter_top DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pin_level    (req_pin_level),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rpm          (rsp_rpm),
      .rsp_rpm_valid    (rsp_rpm_valid),
      .rsp_period_ticks (rsp_period_ticks)
   );

   tach_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pin_level    (req_pin_level),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rpm          (rsp_rpm),
      .rsp_rpm_valid    (rsp_rpm_valid),
      .rsp_period_ticks (rsp_period_ticks),
      .mismatches       (mismatches),
      .readings_pending (readings_pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // disable first so the mode write lands; upper data bits are don't-care
   task automatic set_meter(input logic en, input logic [1:0] mode,
                            input logic [MAXP_W-1:0] stale);
      logic [CSR_DATA_W-1:0] data;
      data    = $urandom();
      data[0] = 1'b0;
      write_reg(CSR_ENABLED, data);
      data      = $urandom();
      data[1:0] = mode;
      write_reg(CSR_EDGE_MODE, data);
      write_reg(CSR_MAX_PERIOD, stale);
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_UNUSED, $urandom());
      data    = $urandom();
      data[0] = en;
      write_reg(CSR_ENABLED, data);
   endtask

   task automatic send_word(input logic pin, input logic rst);
      int   gap;
      logic taken;
      gap = steady ? 0 : draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pin_level <= pin;
      req_restart   <= rst;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // drop valid and wait until every reading has come back
   task automatic end_phase();
      req_valid <= 1'b0;
      do @(negedge clock); while (readings_pending != 0);
      @(posedge clock);
   endtask

   // result side: runs of ready broken by stalls
   initial begin
      int run;
      int stall;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
         repeat (run) @(posedge clock);
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic              pin;
      logic              rst;
      logic              en;
      logic [MAXP_W-1:0] stale;
      bit                noisy;
      int                base;
      int                hold;
      int                sel;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, disabled: pin tracked, nothing measured
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);
      end_phase();

      write_reg(CSR_ENABLED, 32'd1);
      send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);   // first edge only sets the reference
      send_word(1'b0, 1'b0);
      send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b1);   // restart drops the period
      send_word(1'b1, 1'b0);   // one-tick period, top rpm
      end_phase();

      // mode write while measuring must be ignored
      write_reg(CSR_EDGE_MODE, {30'd0, MODE_FALL});
      send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);
      end_phase();

      // zero timeout: every reading stale
      set_meter(1'b1, MODE_FALL, '0);
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b0);
      end_phase();

      // low level mode, timeout of one tick
      set_meter(1'b1, MODE_LOW, 32'd1);
      send_word(1'b0, 1'b0);
      send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b0);
      end_phase();

      set_meter(1'b1, MODE_CHANGE, '1);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b1);
      send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);
      end_phase();

      // random phases: square waves with jitter, some noise, rare restarts
      for (int p = 0; p < 8; p++) begin
         en  = ($urandom_range(0, 4) != 0);
         sel = $urandom_range(0, 9);
         case (sel)
            0:       stale = '0;
            1:       stale = 32'd1;
            2, 3, 4: stale = $urandom_range(2, 40);
            5:       stale = MAX_PERIOD_RST;
            6:       stale = '1;
            7:       stale = $urandom();
            default: stale = $urandom_range(20, 400);
         endcase
         set_meter(en, 2'($urandom_range(0, 3)), stale);
         if (en && $urandom_range(0, 2) == 0)
            write_reg(CSR_EDGE_MODE, $urandom());
         steady = ($urandom_range(0, 3) == 0);
         noisy  = ($urandom_range(0, 5) == 0);
         base   = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 20);
         pin    = 1'($urandom_range(0, 1));
         hold   = base;
         for (int i = 0; i < 56; i++) begin
            rst = ($urandom_range(0, 39) == 0);
            if (noisy) begin
               pin = 1'($urandom_range(0, 1));
            end else if (hold <= 0) begin
               pin  = !pin;
               hold = base + $urandom_range(0, 2);
            end
            send_word(pin, rst);
            hold--;
         end
         end_phase();
      end

      steady = 1'b0;
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
